// ===== rtl/core/mthm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package mthm_pkg;
  localparam int unsigned SlotsDefault = 32;
  localparam logic [7:0] LimitReset = 8'd3;

  localparam logic [2:0] CmdTick  = 3'd0;
  localparam logic [2:0] CmdReg   = 3'd1;
  localparam logic [2:0] CmdBeat  = 3'd2;
  localparam logic [2:0] CmdCheck = 3'd3;
  localparam logic [2:0] CmdQuery = 3'd4;
  localparam logic [2:0] CmdSys   = 3'd5;

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StFull    = 2'd1;
  localparam logic [1:0] StUnknown = 2'd2;
  localparam logic [1:0] StZeroTmo = 2'd3;

  localparam logic [1:0] HealthOk   = 2'd0;
  localparam logic [1:0] HealthWarn = 2'd1;
  localparam logic [1:0] HealthCrit = 2'd2;

  // Per-cycle operation broadcast to every cell; check, write and stamp act only in the head cell.
  typedef struct packed {
    logic        rotate;   // hand slot to neighbor
    logic        check;    // evaluate timeout on slot now at cell 0
    logic        write;    // load new client into slot at cell 0
    logic        stamp;    // restamp slot at cell 0
    logic [31:0] clock;
    logic [31:0] id;
    logic [31:0] tmo;
    logic [7:0]  limit;
  } op_t;

  typedef struct packed {
    logic        used;
    logic [31:0] client;
    logic [31:0] tmo;
    logic [31:0] beat;
    logic [7:0]  misses;
    logic [1:0]  health;
  } slot_t;
endpackage
`default_nettype wire

// ===== rtl/core/mthm_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
module mthm_cell (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             head_i,
  input  mthm_pkg::op_t   op_i,
  input  mthm_pkg::slot_t nbr_i,
  output mthm_pkg::slot_t slot_o
);
  mthm_pkg::slot_t s_q, s_d, src;
  logic [31:0] elapsed;
  logic [7:0]  miss_inc;

  always_comb begin
    src = op_i.rotate ? nbr_i : s_q;
    s_d = src;
    elapsed = op_i.clock - src.beat;
    miss_inc = (src.misses == 8'hff) ? src.misses : src.misses + 8'd1;
    if (head_i && op_i.check && src.used) begin
      if (elapsed > src.tmo) begin
        s_d.misses = miss_inc;
        s_d.health = (miss_inc >= op_i.limit) ? mthm_pkg::HealthCrit
                                              : mthm_pkg::HealthWarn;
      end else begin
        s_d.misses = 8'd0;
        s_d.health = mthm_pkg::HealthOk;
      end
    end
    if (head_i && op_i.write) begin
      s_d.used   = 1'b1;
      s_d.client = op_i.id;
      s_d.tmo    = op_i.tmo;
      s_d.beat   = op_i.clock;
      s_d.misses = 8'd0;
      s_d.health = mthm_pkg::HealthOk;
    end
    if (head_i && op_i.stamp) s_d.beat = op_i.clock;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s_q <= '0;
    else s_q <= s_d;
  end
  assign slot_o = s_q;
endmodule
`default_nettype wire

// ===== rtl/core/multi_task_heartbeat_monitor.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Tick, zero-timeout register and unknown commands go straight to the output; register, heartbeat,
// queries make one pass of the slot ring; check makes two (update ring pass, then worst-health pass).
// A new command is taken only in idle, after the last result has been accepted; while a command
// walks, the slot ring rotates one cell per cycle past the update point.
// Reset: clock and used flags cleared, limit set to 3, asynchronously; no clearing pass.
module multi_task_heartbeat_monitor #(
  parameter int unsigned SLOTS = mthm_pkg::SlotsDefault
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_ready_o,
  input  wire  [2:0]  cmd_i,
  input  wire  [31:0] client_id_i,
  input  wire  [31:0] timeout_limit_ms_i,
  output logic        out_valid_o,
  input  wire         out_ready_i,
  output logic [1:0]  status_o,
  output logic [1:0]  health_level_o,
  output logic [4:0]  slot_index_o,
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire  [7:0]  cfg_data_i
);
  localparam int CW = $clog2(SLOTS + 1);
  localparam logic [1:0] SIdle = 2'd0, SWalk = 2'd1, SOut = 2'd2;

  logic [1:0]  state_q, state_d;
  logic [31:0] clock_q, clock_d;
  logic [7:0]  limit_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] pos_q, pos_d;   // slot index currently at cell 0
  logic [2:0]  cmd_q, cmd_d;
  logic [31:0] id_q, id_d, tmo_q, tmo_d;
  logic        done_q, done_d;
  logic [1:0]  st_q, st_d, hl_q, hl_d;
  logic [4:0]  ix_q, ix_d;

  mthm_pkg::op_t   op;
  mthm_pkg::slot_t slots [SLOTS];
  mthm_pkg::slot_t head;

  // the last cell receives the slot leaving cell 0 and applies the update to it
  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    mthm_cell u_cell (
      .clk_i, .rst_ni,
      .head_i (g == SLOTS - 1),
      .op_i   (op),
      .nbr_i  (slots[(g + 1) % SLOTS]),
      .slot_o (slots[g])
    );
  end
  assign head = slots[0];

  assign in_ready_o  = (state_q == SIdle);
  assign out_valid_o = (state_q == SOut);
  assign cfg_ready_o = 1'b1;
  assign status_o = st_q;
  assign health_level_o = hl_q;
  assign slot_index_o = ix_q;

  logic hit;
  always_comb begin
    state_d = state_q; clock_d = clock_q; cnt_d = cnt_q; pos_d = pos_q;
    cmd_d = cmd_q; id_d = id_q; tmo_d = tmo_q; done_d = done_q;
    st_d = st_q; hl_d = hl_q; ix_d = ix_q;
    op = '0;
    op.clock = clock_q; op.id = id_q; op.tmo = tmo_q; op.limit = limit_q;
    hit = 1'b0;
    case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          cmd_d = cmd_i; id_d = client_id_i; tmo_d = timeout_limit_ms_i;
          st_d = mthm_pkg::StOk; hl_d = mthm_pkg::HealthOk; ix_d = '0;
          done_d = 1'b0; cnt_d = '0;
          case (cmd_i)
            mthm_pkg::CmdTick: begin
              clock_d = clock_q + 32'd1; state_d = SOut;
            end
            mthm_pkg::CmdReg: begin
              if (timeout_limit_ms_i == '0) begin
                st_d = mthm_pkg::StZeroTmo; state_d = SOut;
              end else begin
                st_d = mthm_pkg::StFull; state_d = SWalk;
              end
            end
            mthm_pkg::CmdBeat, mthm_pkg::CmdQuery: begin
              st_d = mthm_pkg::StUnknown; state_d = SWalk;
            end
            mthm_pkg::CmdCheck, mthm_pkg::CmdSys: state_d = SWalk;
            default: state_d = SOut;
          endcase
        end
      end
      SWalk: begin
        op.rotate = 1'b1;
        case (cmd_q)
          mthm_pkg::CmdReg: begin
            hit = !done_q && !head.used;
            op.write = hit;
          end
          mthm_pkg::CmdBeat, mthm_pkg::CmdQuery: begin
            hit = !done_q && head.used && head.client == id_q;
            op.stamp = hit && (cmd_q == mthm_pkg::CmdBeat);
          end
          mthm_pkg::CmdCheck: op.check = 1'b1;
          default: ;
        endcase
        if (hit) begin
          done_d = 1'b1; st_d = mthm_pkg::StOk;
          ix_d = 5'(pos_q);
          if (cmd_q != mthm_pkg::CmdReg) hl_d = head.health;
        end
        // worst health: for check, the cell 0 value is pre-update, so take it from
        // the slots arriving back after the full ring, in the sys pass below
        if (cmd_q == mthm_pkg::CmdSys && head.used && head.health > hl_q)
          hl_d = head.health;
        if (cnt_q == CW'(SLOTS - 1)) begin
          state_d = (cmd_q == mthm_pkg::CmdCheck) ? SWalk : SOut;
          if (cmd_q == mthm_pkg::CmdCheck) cmd_d = mthm_pkg::CmdSys;
          cnt_d = '0;
        end else cnt_d = cnt_q + CW'(1);
        pos_d = (pos_q == CW'(SLOTS - 1)) ? '0 : pos_q + CW'(1);
      end
      SOut: if (out_ready_i) state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle; clock_q <= '0; limit_q <= mthm_pkg::LimitReset;
      cnt_q <= '0; pos_q <= '0; done_q <= 1'b0;
    end else begin
      state_q <= state_d; clock_q <= clock_d; cnt_q <= cnt_d;
      pos_q <= pos_d; done_q <= done_d;
      if (cfg_valid_i) limit_q <= cfg_data_i;
    end
  end
  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d; id_q <= id_d; tmo_q <= tmo_d;
    st_q <= st_d; hl_q <= hl_d; ix_q <= ix_d;
  end
endmodule
`default_nettype wire
